// File: hw/rtl/euler_yxz_view_matrix_defines.svh
// Assertion helpers for the Euler Y-X-Z view matrix block.
// Both use the clock i_clk, and EYVM_ASSERT the active-low reset i_rst_n, of the module that uses them.
`ifndef EULER_YXZ_VIEW_MATRIX_DEFINES_SVH
`define EULER_YXZ_VIEW_MATRIX_DEFINES_SVH

// Checked only outside reset
`define EYVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define EYVM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/euyxz_pkg.sv
package euyxz_pkg;

    localparam int CORDIC_STAGES = 17;
    localparam int XW = 31;   // CORDIC x/y width
    localparam int ZW = 20;   // CORDIC angle width (Q.16)

    localparam logic signed [XW-1:0] CORDIC_X0   = 31'sd163008219;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ZW-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [15:0]   ONE_Q14     = 16'sd16384;

    localparam logic [15:0] ATAN_TAB [0:CORDIC_STAGES-1] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047,
        16'd1024, 16'd512, 16'd256, 16'd128, 16'd64, 16'd32, 16'd16,
        16'd8, 16'd4, 16'd2, 16'd1
    };

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] u_x;
        logic signed [15:0] u_y;
        logic signed [15:0] u_z;
        logic signed [15:0] v_x;
        logic signed [15:0] v_y;
        logic signed [15:0] v_z;
        logic signed [15:0] w_x;
        logic signed [15:0] w_y;
        logic signed [15:0] w_z;
        logic signed [31:0] trans_u;
        logic signed [31:0] trans_v;
        logic signed [31:0] trans_w;
    } t_out;

    // One CORDIC lane
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_lane;

    // Item as it moves down the CORDIC chain.
    // lane 0: angle_x, lane 1: angle_y, lane 2: angle_z
    typedef struct packed {
        t_lane [2:0]        lane;
        logic [2:0]         neg;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_cord;

endpackage

// File: hw/rtl/euyxz_cordic_cell.sv
module euyxz_cordic_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [4:0]           i_shift,
    input  logic [15:0]          i_atan,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  euyxz_pkg::t_cord     i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output euyxz_pkg::t_cord     o_data
);
    import euyxz_pkg::*;

    logic  r_vld;
    t_cord r_data;
    t_cord n_data;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    // One micro-rotation on each of the three lanes
    always_comb begin
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] at;
        n_data = i_data;
        at     = {4'b0, i_atan};
        for (int k = 0; k < 3; k++) begin
            xs = i_data.lane[k].x >>> i_shift;
            ys = i_data.lane[k].y >>> i_shift;
            if (!i_data.lane[k].z[ZW-1]) begin
                n_data.lane[k].x = i_data.lane[k].x - ys;
                n_data.lane[k].y = i_data.lane[k].y + xs;
                n_data.lane[k].z = i_data.lane[k].z - at;
            end else begin
                n_data.lane[k].x = i_data.lane[k].x + ys;
                n_data.lane[k].y = i_data.lane[k].y - xs;
                n_data.lane[k].z = i_data.lane[k].z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// File: hw/rtl/euyxz_matrix.sv
module euyxz_matrix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  euyxz_pkg::t_cord     i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output euyxz_pkg::t_out      o_data
);
    import euyxz_pkg::*;
    `include "euler_yxz_view_matrix_defines.svh"

    localparam int NSTG = 7;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;

    // Stage 1: sine and cosine in Q1.14
    logic signed [15:0] r1_sn [3];
    logic signed [15:0] r1_cs [3];
    logic signed [31:0] r1_px, r1_py, r1_pz;
    // Stage 2: two-factor products
    logic signed [31:0] r2_c1c3, r2_s1s2, r2_c2s3, r2_c1s2, r2_c3s1;
    logic signed [31:0] r2_c1s3, r2_c2c3, r2_s1s3, r2_c2s1, r2_c1c2;
    logic signed [15:0] r2_s2, r2_s3;
    logic signed [31:0] r2_px, r2_py, r2_pz;
    // Stage 3: three-factor products
    logic signed [47:0] r3_uxt, r3_uzt, r3_vxt, r3_vzt;
    logic signed [31:0] r3_c1c3, r3_c3s1, r3_c1s3, r3_s1s3;
    logic signed [31:0] r3_c2s3, r3_c2c3, r3_c2s1, r3_c1c2;
    logic signed [15:0] r3_s2;
    logic signed [31:0] r3_px, r3_py, r3_pz;
    // Stage 4: rotation entries
    logic signed [15:0] r4_e [9];
    logic signed [31:0] r4_px, r4_py, r4_pz;
    // Stage 5: entry times position
    logic signed [15:0] r5_e [9];
    logic signed [47:0] r5_p [9];
    // Stage 6: dot products
    logic signed [15:0] r6_e [9];
    logic signed [49:0] r6_d [3];
    // Stage 7: output
    t_out r_out;

    function automatic logic signed [15:0] f_trig(input logic signed [XW-1:0] a,
                                                  input logic neg);
        logic signed [XW-1:0] r;
        logic signed [15:0]   c;
        r = (a + 31'sd8192) >>> 14;
        if (r > 31'sd16384) begin
            c = ONE_Q14;
        end else if (r < -31'sd16384) begin
            c = -ONE_Q14;
        end else begin
            c = 16'(r);
        end
        return neg ? -c : c;
    endfunction

    // Q.42 sum to Q1.14, round half up and clamp
    function automatic logic signed [15:0] f_entry(input logic signed [47:0] a);
        logic signed [47:0] r;
        r = (a + 48'sd134217728) >>> 28;
        if (r > 48'sd16384) begin
            return ONE_Q14;
        end else if (r < -48'sd16384) begin
            return -ONE_Q14;
        end
        return 16'(r);
    endfunction

    // Negate, round Q.30 to Q.16, saturate to 32 bits
    function automatic logic signed [31:0] f_trans(input logic signed [49:0] d);
        logic signed [50:0] r;
        r = (-51'(d) + 51'sd8192) >>> 14;
        if (r > 51'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (r < -51'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(r);
    endfunction

    // Stall chain: a stage loads when it is empty or the next one loads
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int k = 0; k < 3; k++) begin
                r1_cs[k] <= f_trig(i_data.lane[k].x, i_data.neg[k]);
                r1_sn[k] <= f_trig(i_data.lane[k].y, i_data.neg[k]);
            end
            r1_px <= i_data.pos_x;
            r1_py <= i_data.pos_y;
            r1_pz <= i_data.pos_z;
        end
    end

    // Stage 2: c1,s1 lane 1; c2,s2 lane 0; c3,s3 lane 2
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r2_c1c3 <= r1_cs[1] * r1_cs[2];
            r2_s1s2 <= r1_sn[1] * r1_sn[0];
            r2_c2s3 <= r1_cs[0] * r1_sn[2];
            r2_c1s2 <= r1_cs[1] * r1_sn[0];
            r2_c3s1 <= r1_cs[2] * r1_sn[1];
            r2_c1s3 <= r1_cs[1] * r1_sn[2];
            r2_c2c3 <= r1_cs[0] * r1_cs[2];
            r2_s1s3 <= r1_sn[1] * r1_sn[2];
            r2_c2s1 <= r1_cs[0] * r1_sn[1];
            r2_c1c2 <= r1_cs[1] * r1_cs[0];
            r2_s2   <= r1_sn[0];
            r2_s3   <= r1_sn[2];
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_pz   <= r1_pz;
        end
    end

    // Stage 3
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r3_uxt  <= r2_s1s2 * r2_s3;
            r3_uzt  <= r2_c1s2 * r2_s3;
            r3_vxt  <= r2_c3s1 * r2_s2;
            r3_vzt  <= r2_c1c3 * r2_s2;
            r3_c1c3 <= r2_c1c3;
            r3_c3s1 <= r2_c3s1;
            r3_c1s3 <= r2_c1s3;
            r3_s1s3 <= r2_s1s3;
            r3_c2s3 <= r2_c2s3;
            r3_c2c3 <= r2_c2c3;
            r3_c2s1 <= r2_c2s1;
            r3_c1c2 <= r2_c1c2;
            r3_s2   <= r2_s2;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_pz   <= r2_pz;
        end
    end

    // Stage 4: two-factor terms move to the Q.42 scale
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r4_e[0] <= f_entry((48'(r3_c1c3) <<< 14) + r3_uxt);
            r4_e[1] <= f_entry(48'(r3_c2s3) <<< 14);
            r4_e[2] <= f_entry(r3_uzt - (48'(r3_c3s1) <<< 14));
            r4_e[3] <= f_entry(r3_vxt - (48'(r3_c1s3) <<< 14));
            r4_e[4] <= f_entry(48'(r3_c2c3) <<< 14);
            r4_e[5] <= f_entry(r3_vzt + (48'(r3_s1s3) <<< 14));
            r4_e[6] <= f_entry(48'(r3_c2s1) <<< 14);
            r4_e[7] <= -r3_s2;
            r4_e[8] <= f_entry(48'(r3_c1c2) <<< 14);
            r4_px   <= r3_px;
            r4_py   <= r3_py;
            r4_pz   <= r3_pz;
        end
    end

    // Stage 5
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            for (int k = 0; k < 3; k++) begin
                r5_p[3*k]   <= r4_e[3*k]   * r4_px;
                r5_p[3*k+1] <= r4_e[3*k+1] * r4_py;
                r5_p[3*k+2] <= r4_e[3*k+2] * r4_pz;
            end
            r5_e <= r4_e;
        end
    end

    // Stage 6
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int k = 0; k < 3; k++) begin
                r6_d[k] <= 50'(r5_p[3*k]) + 50'(r5_p[3*k+1]) + 50'(r5_p[3*k+2]);
            end
            r6_e <= r5_e;
        end
    end

    // Stage 7: output register
    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_out.u_x     <= r6_e[0];
            r_out.u_y     <= r6_e[1];
            r_out.u_z     <= r6_e[2];
            r_out.v_x     <= r6_e[3];
            r_out.v_y     <= r6_e[4];
            r_out.v_z     <= r6_e[5];
            r_out.w_x     <= r6_e[6];
            r_out.w_y     <= r6_e[7];
            r_out.w_z     <= r6_e[8];
            r_out.trans_u <= f_trans(r6_d[0]);
            r_out.trans_v <= f_trans(r6_d[1]);
            r_out.trans_w <= f_trans(r6_d[2]);
        end
    end

    `EYVM_ASSERT_ALWAYS(a_rst_empty, $past(!i_rst_n) |-> r_vld == '0, "pipe not empty after reset")
    `EYVM_ASSERT(a_full_stall, !o_ready |-> &r_vld, "input stalled with a bubble in the pipe")
    `EYVM_ASSERT(a_w_y_range, o_valid |-> (r_out.w_y <= ONE_Q14 && r_out.w_y >= -ONE_Q14), "w_y out of range")

endmodule

// File: hw/rtl/euler_yxz_view_matrix.sv
// Euler Y-X-Z view matrix: takes yaw/pitch/roll (Q3.13) and a camera position (Q16.16)
// and returns the nine Q1.14 rotation entries and three saturated Q16.16 translations.
// Fully pipelined: one item per cycle while the output is not stalled, through 17 CORDIC
// cells, each turning all three angles by one micro-rotation, then 7 product/rounding
// stages with the output register counted among them.
// Back-pressure stalls only the full stages; bubbles are squeezed out.
module euler_yxz_view_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  euyxz_pkg::t_in     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output euyxz_pkg::t_out    o_data
);
    import euyxz_pkg::*;

    t_cord w_start;
    t_cord w_dat [0:CORDIC_STAGES];
    logic  w_vld [0:CORDIC_STAGES];
    logic  w_rdy [0:CORDIC_STAGES];

    // Range reduction into [-pi/2, pi/2] and CORDIC start values
    always_comb begin
        logic signed [15:0]   ang [3];
        logic signed [ZW-1:0] z;
        ang[0] = i_data.angle_x;
        ang[1] = i_data.angle_y;
        ang[2] = i_data.angle_z;
        w_start.pos_x = i_data.pos_x;
        w_start.pos_y = i_data.pos_y;
        w_start.pos_z = i_data.pos_z;
        for (int k = 0; k < 3; k++) begin
            z = {{(ZW-19){ang[k][15]}}, ang[k], 3'b000};
            w_start.lane[k].x = CORDIC_X0;
            w_start.lane[k].y = '0;
            if (z > HALF_PI_Q16) begin
                w_start.lane[k].z = z - PI_Q16;
                w_start.neg[k]    = 1'b1;
            end else if (z < -HALF_PI_Q16) begin
                w_start.lane[k].z = z + PI_Q16;
                w_start.neg[k]    = 1'b1;
            end else begin
                w_start.lane[k].z = z;
                w_start.neg[k]    = 1'b0;
            end
        end
    end

    assign w_dat[0] = w_start;
    assign w_vld[0] = i_valid;
    assign o_ready  = w_rdy[0];

    // CORDIC chain
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        euyxz_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (5'(g)),
            .i_atan  (ATAN_TAB[g]),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_dat[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_dat[g+1])
        );
    end

    // Products, rounding and translations
    euyxz_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[CORDIC_STAGES]),
        .o_ready (w_rdy[CORDIC_STAGES]),
        .i_data  (w_dat[CORDIC_STAGES]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
